// File: hdl/vfae_pkg.sv
// ----------------------------------------------------------------------------
// vfae_pkg
// Shared types and constants of the voxel face and occlusion extractor:
// grid limits, register indexes, read kinds, controller states and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package vfae_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int MAX_DEPTH  = 32;

   localparam int COORD_W  = 6;   // request coordinates and grid registers
   localparam int SCOORD_W = 8;   // signed working coordinates, -1..64
   localparam int X_AW     = $clog2(MAX_WIDTH);
   localparam int Y_AW     = $clog2(MAX_HEIGHT);
   localparam int Z_AW     = $clog2(MAX_DEPTH);
   localparam int MEM_AW   = X_AW + Y_AW + Z_AW;
   localparam int MEM_DEPTH = 1 << MEM_AW;

   localparam logic [COORD_W-1:0] GRID_RESET = COORD_W'(32);

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] NBR_LAST_CNT = CNT_W'(4);
   localparam logic [CNT_W-1:0] AO_READS     = CNT_W'(8);
   localparam logic [CNT_W-1:0] AO_EMIT_CNT  = CNT_W'(9);

   typedef enum logic [1:0] {
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_DEPTH
   } csr_index_type;

   typedef enum logic {
      OP_WRITE,
      OP_SCAN
   } opcode_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [1:0] {
      RD_MID,
      RD_NBR,
      RD_AO
   } rd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_NBR,
      ST_PICK,
      ST_AO
   } ctrl_state_type;

   typedef struct packed {
      logic        load;      // capture request fields
      logic        mem_we;    // store the captured voxel
      logic        rd_en;     // issue one grid read
      rd_kind_type rd_kind;
      axis_type    axis;      // axis of the read or of the emitted face
      logic [2:0]  rd_slot;   // occlusion neighbor slot
      logic        emit;      // present one face
      logic        last;      // face is the final one of the scan
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] face_mask;  // one bit per axis with a face
   } dp_status_type;

endpackage

// File: hdl/vfae_ctrl.sv
// ----------------------------------------------------------------------------
// vfae_ctrl
// Sequencer of the extractor: accepts requests, issues voxel writes, and for
// scans steps the datapath through the center and neighbor reads, then through
// eight occlusion reads and one emit per face.
// ----------------------------------------------------------------------------
module vfae_ctrl
   import vfae_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_opcode,
   output logic          busy,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   axis_type         axis_ff, axis_in;
   logic [2:0]       pend_ff, pend_in;

   function automatic axis_type lowest_axis(input logic [2:0] m);
      priority if (m[0]) begin
         return AXIS_X;
      end else if (m[1]) begin
         return AXIS_Y;
      end else begin
         return AXIS_Z;
      end
   endfunction

   function automatic logic [2:0] drop_axis(input logic [2:0] m, input axis_type a);
      logic [2:0] r;
      r = m;
      unique case (a)
         AXIS_X:  r[0] = 1'b0;
         AXIS_Y:  r[1] = 1'b0;
         AXIS_Z:  r[2] = 1'b0;
         default: r = m;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= AXIS_X;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      axis_in     = axis_ff;
      pend_in     = pend_ff;
      cmd         = '0;
      cmd.rd_kind = RD_MID;
      cmd.axis    = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               if (opcode_type'(req_opcode) == OP_WRITE) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_NBR;
               end
            end
         end
         ST_WRITE: begin
            cmd.mem_we = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_NBR: begin
            // center first, then one neighbor per axis
            if (cnt_ff == '0) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_kind = RD_MID;
            end else if (cnt_ff != NBR_LAST_CNT) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_kind = RD_NBR;
               cmd.axis    = axis_type'(cnt_ff[1:0] - 2'd1);
            end
            if (cnt_ff == NBR_LAST_CNT) begin
               state_in = ST_PICK;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_PICK: begin
            cnt_in = '0;
            if (status.face_mask == '0) begin
               state_in = ST_IDLE;
            end else begin
               axis_in  = lowest_axis(status.face_mask);
               pend_in  = drop_axis(status.face_mask, lowest_axis(status.face_mask));
               state_in = ST_AO;
            end
         end
         ST_AO: begin
            if (cnt_ff < AO_READS) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_kind = RD_AO;
               cmd.rd_slot = cnt_ff[2:0];
            end
            if (cnt_ff == AO_EMIT_CNT) begin
               cmd.emit = 1'b1;
               cmd.last = (pend_ff == '0);
               cnt_in   = '0;
               if (pend_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  axis_in = lowest_axis(pend_ff);
                  pend_in = drop_axis(pend_ff, lowest_axis(pend_ff));
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (state_ff == ST_AO && cnt_ff == AO_EMIT_CNT))
      else $error("face emitted outside the emit step");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> !busy)
      else $error("final face did not end the scan");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_we && cmd.rd_en))
      else $error("grid write and read in the same cycle");

endmodule

// File: hdl/vfae_dp.sv
// ----------------------------------------------------------------------------
// vfae_dp
// Datapath: request and grid size registers, voxel memory with boundary
// rule, captured center/neighbor/occlusion bits, and the face output
// register.
// ----------------------------------------------------------------------------
module vfae_dp
   import vfae_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic [COORD_W-1:0]         req_cell_x,
   input  logic [COORD_W-1:0]         req_cell_y,
   input  logic [COORD_W-1:0]         req_cell_z,
   input  logic                       req_voxel_value,
   input  logic                       csr_valid,
   input  logic [1:0]                 csr_index,
   input  logic [COORD_W-1:0]         csr_data,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_face_axis,
   output logic                       rsp_normal_negative,
   output logic signed [COORD_W-1:0]  rsp_base_x,
   output logic signed [COORD_W-1:0]  rsp_base_y,
   output logic [COORD_W-1:0]         rsp_base_z,
   output logic [1:0]                 rsp_occlusion_a,
   output logic [1:0]                 rsp_occlusion_b,
   output logic [1:0]                 rsp_occlusion_c,
   output logic [1:0]                 rsp_occlusion_d,
   output logic                       rsp_last_face
);

   // grid size registers
   logic [COORD_W-1:0] width_ff, height_ff, depth_ff;
   // captured request
   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic               val_ff;
   // read pipeline
   logic               voxel_mem [MEM_DEPTH];
   logic               mem_q_ff;
   logic               forced_ff, fval_ff;
   logic               tag_valid_ff;
   rd_kind_type        tag_kind_ff;
   axis_type           tag_axis_ff;
   logic [2:0]         tag_slot_ff;
   // captured cells: occlusion slots are top, left, bottom, right, tl, tr, bl, br
   logic               mid_ff;
   logic [2:0]         nb_ff;
   logic [7:0]         ao_ff;
   // face output
   logic                      rsp_valid_ff;
   axis_type                  rsp_axis_ff;
   logic                      rsp_neg_ff;
   logic [COORD_W-1:0]        rsp_bx_ff, rsp_by_ff, rsp_bz_ff;
   logic [1:0]                rsp_a_ff, rsp_b_ff, rsp_c_ff, rsp_d_ff;
   logic                      rsp_last_ff;

   logic [COORD_W-1:0]         w_eff, h_eff, d_eff;
   logic signed [1:0]          du, dv, dn, dx, dy, dz;
   logic signed [SCOORD_W-1:0] rx, ry, rz;
   logic                       rd_forced, rd_fval;
   logic [MEM_AW-1:0]          rd_addr, wr_addr, mem_addr;
   logic                       wr_in_range;
   logic                       rd_bit;
   logic signed [SCOORD_W-1:0] tx, ty, hx, hy;

   function automatic logic [COORD_W-1:0] eff_dim(input logic [COORD_W-1:0] r,
                                                  input int m);
      if (int'(r) > m) begin
         return COORD_W'(m);
      end
      return r;
   endfunction

   function automatic logic [1:0] ao_level(input logic s0, input logic s1,
                                           input logic c);
      if (s0 && s1) begin
         return 2'd3;
      end
      return 2'({1'b0, s0} + {1'b0, s1} + {1'b0, c});
   endfunction

   assign w_eff = eff_dim(width_ff, MAX_WIDTH);
   assign h_eff = eff_dim(height_ff, MAX_HEIGHT);
   assign d_eff = eff_dim(depth_ff, MAX_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GRID_RESET;
         height_ff <= GRID_RESET;
         depth_ff  <= GRID_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_index == CSR_HEIGHT) begin
            height_ff <= csr_data;
         end
         if (csr_index == CSR_DEPTH) begin
            depth_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= req_cell_x;
         y_ff   <= req_cell_y;
         z_ff   <= req_cell_z;
         val_ff <= req_voxel_value;
      end
   end

   // offsets of the requested read
   always_comb begin
      du = '0;
      dv = '0;
      dn = '0;
      unique case (cmd.rd_kind)
         RD_MID: begin
            dn = '0;
         end
         RD_NBR: begin
            dn = -2'sd1;
         end
         RD_AO: begin
            // a solid center moves the face onto its neighbor
            dn = mid_ff ? -2'sd1 : 2'sd0;
            unique case (cmd.rd_slot)
               3'd0: begin du = 2'sd0;  dv = -2'sd1; end
               3'd1: begin du = -2'sd1; dv = 2'sd0;  end
               3'd2: begin du = 2'sd0;  dv = 2'sd1;  end
               3'd3: begin du = 2'sd1;  dv = 2'sd0;  end
               3'd4: begin du = -2'sd1; dv = -2'sd1; end
               3'd5: begin du = 2'sd1;  dv = -2'sd1; end
               3'd6: begin du = -2'sd1; dv = 2'sd1;  end
               default: begin du = 2'sd1; dv = 2'sd1; end
            endcase
         end
         default: begin
            dn = '0;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.axis)
         AXIS_X: begin dx = dn; dy = du; dz = dv; end
         AXIS_Y: begin dx = dv; dy = dn; dz = du; end
         AXIS_Z: begin dx = du; dy = dv; dz = dn; end
         default: begin dx = '0; dy = '0; dz = '0; end
      endcase
   end

   assign rx = $signed(SCOORD_W'(x_ff)) + SCOORD_W'(dx);
   assign ry = $signed(SCOORD_W'(y_ff)) + SCOORD_W'(dy);
   assign rz = $signed(SCOORD_W'(z_ff)) + SCOORD_W'(dz);

   // boundary rule: below the floor is empty, any other outside cell solid
   always_comb begin
      rd_forced = 1'b0;
      rd_fval   = 1'b0;
      priority if (rz < 0) begin
         rd_forced = 1'b1;
         rd_fval   = 1'b0;
      end else if (rx < 0 || rx >= $signed(SCOORD_W'(w_eff)) ||
                   ry < 0 || ry >= $signed(SCOORD_W'(h_eff)) ||
                   rz >= $signed(SCOORD_W'(d_eff))) begin
         rd_forced = 1'b1;
         rd_fval   = 1'b1;
      end else begin
         rd_forced = 1'b0;
      end
   end

   assign rd_addr     = {rz[Z_AW-1:0], ry[Y_AW-1:0], rx[X_AW-1:0]};
   assign wr_addr     = {z_ff[Z_AW-1:0], y_ff[Y_AW-1:0], x_ff[X_AW-1:0]};
   assign wr_in_range = (x_ff < w_eff) && (y_ff < h_eff) && (z_ff < d_eff);
   assign mem_addr    = cmd.mem_we ? wr_addr : rd_addr;

   always_ff @(posedge clock) begin
      if (cmd.mem_we && wr_in_range) begin
         voxel_mem[mem_addr] <= val_ff;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= voxel_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else begin
         tag_valid_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         forced_ff   <= rd_forced;
         fval_ff     <= rd_fval;
         tag_kind_ff <= cmd.rd_kind;
         tag_axis_ff <= cmd.axis;
         tag_slot_ff <= cmd.rd_slot;
      end
   end

   assign rd_bit = forced_ff ? fval_ff : mem_q_ff;

   // capture each read from the registered memory output and its registered tag
   always_ff @(posedge clock) begin
      if (tag_valid_ff) begin
         unique case (tag_kind_ff)
            RD_MID: mid_ff <= rd_bit;
            RD_NBR: begin
               unique case (tag_axis_ff)
                  AXIS_X:  nb_ff[0] <= rd_bit;
                  AXIS_Y:  nb_ff[1] <= rd_bit;
                  AXIS_Z:  nb_ff[2] <= rd_bit;
                  default: nb_ff[2] <= rd_bit;
               endcase
            end
            RD_AO:   ao_ff[tag_slot_ff] <= rd_bit;
            default: mid_ff <= rd_bit;
         endcase
      end
   end

   assign status.face_mask = {(nb_ff[2] != mid_ff) && mid_ff,
                              nb_ff[1] != mid_ff,
                              nb_ff[0] != mid_ff};

   // screen base: (2c - size) / 2 truncated toward zero
   assign tx = $signed({1'b0, x_ff, 1'b0}) - $signed(SCOORD_W'(width_ff));
   assign ty = $signed({1'b0, y_ff, 1'b0}) - $signed(SCOORD_W'(height_ff));
   assign hx = (tx >>> 1) + $signed(SCOORD_W'(tx[SCOORD_W-1] & tx[0]));
   assign hy = (ty >>> 1) + $signed(SCOORD_W'(ty[SCOORD_W-1] & ty[0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_axis_ff <= cmd.axis;
         rsp_neg_ff  <= mid_ff;
         rsp_bx_ff   <= hx[COORD_W-1:0];
         rsp_by_ff   <= hy[COORD_W-1:0];
         rsp_bz_ff   <= z_ff;
         rsp_a_ff    <= ao_level(ao_ff[0], ao_ff[1], ao_ff[4]);
         rsp_b_ff    <= ao_level(ao_ff[0], ao_ff[3], ao_ff[5]);
         rsp_c_ff    <= ao_level(ao_ff[2], ao_ff[1], ao_ff[6]);
         rsp_d_ff    <= ao_level(ao_ff[2], ao_ff[3], ao_ff[7]);
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_face_axis       = rsp_axis_ff;
   assign rsp_normal_negative = rsp_neg_ff;
   assign rsp_base_x          = $signed(rsp_bx_ff);
   assign rsp_base_y          = $signed(rsp_by_ff);
   assign rsp_base_z          = rsp_bz_ff;
   assign rsp_occlusion_a     = rsp_a_ff;
   assign rsp_occlusion_b     = rsp_b_ff;
   assign rsp_occlusion_c     = rsp_c_ff;
   assign rsp_occlusion_d     = rsp_d_ff;
   assign rsp_last_face       = rsp_last_ff;

   a_z_negative: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_axis_ff == AXIS_Z) |-> rsp_neg_ff)
      else $error("positive z face emitted");

   a_tag_issue: assert property (@(posedge clock) disable iff (reset)
      tag_valid_ff |-> $past(cmd.rd_en))
      else $error("read captured without an issue");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> !tag_valid_ff)
      else $error("voxel write overlaps a pending read");

endmodule

// File: hdl/voxel_face_ao_extractor.sv
// ----------------------------------------------------------------------------
// voxel_face_ao_extractor
// Voxel occupancy grid with face extraction and per-vertex occlusion.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/req_* and are taken when start is high and busy
//   is low. A write request (opcode write) stores one voxel; writes outside
//   the configured size are dropped.
//   A scan request reads the cell and its x, y and z neighbors one step
//   down, then for each axis with a face (z only for a solid cell) eight
//   cells around the face, one read per cycle from the single-port voxel
//   memory. A scan finds at most 3 faces. Each face appears on rsp_* for
//   one cycle with rsp_valid high; the receiver cannot stall, and
//   rsp_last_face marks the final face. A scan with no face produces
//   nothing. Grid size registers are written over csr_* (always ready)
//   while idle; the user must keep to this, as the block does not enforce
//   it. Reset sets the sizes to 32 and idles the sequencer; voxel contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module voxel_face_ao_extractor
   import vfae_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [COORD_W-1:0]         req_cell_x,
   input  logic [COORD_W-1:0]         req_cell_y,
   input  logic [COORD_W-1:0]         req_cell_z,
   input  logic                       req_voxel_value,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [COORD_W-1:0]         csr_data,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_face_axis,
   output logic                       rsp_normal_negative,
   output logic signed [COORD_W-1:0]  rsp_base_x,
   output logic signed [COORD_W-1:0]  rsp_base_y,
   output logic [COORD_W-1:0]         rsp_base_z,
   output logic [1:0]                 rsp_occlusion_a,
   output logic [1:0]                 rsp_occlusion_b,
   output logic [1:0]                 rsp_occlusion_c,
   output logic [1:0]                 rsp_occlusion_d,
   output logic                       rsp_last_face
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   vfae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .cmd        (cmd),
      .status     (status)
   );

   vfae_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_cell_x          (req_cell_x),
      .req_cell_y          (req_cell_y),
      .req_cell_z          (req_cell_z),
      .req_voxel_value     (req_voxel_value),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_face_axis       (rsp_face_axis),
      .rsp_normal_negative (rsp_normal_negative),
      .rsp_base_x          (rsp_base_x),
      .rsp_base_y          (rsp_base_y),
      .rsp_base_z          (rsp_base_z),
      .rsp_occlusion_a     (rsp_occlusion_a),
      .rsp_occlusion_b     (rsp_occlusion_b),
      .rsp_occlusion_c     (rsp_occlusion_c),
      .rsp_occlusion_d     (rsp_occlusion_d),
      .rsp_last_face       (rsp_last_face)
   );

endmodule

// File: sim/voxel_face_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_checker
// Watches the request, register and face channels of the extractor, keeps
// its own copy of the voxel grid and grid sizes, predicts the faces of each
// scan request and compares every face that comes out, in order.
// ----------------------------------------------------------------------------
module voxel_face_checker
   import vfae_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_opcode,
   input  logic [COORD_W-1:0]        req_cell_x,
   input  logic [COORD_W-1:0]        req_cell_y,
   input  logic [COORD_W-1:0]        req_cell_z,
   input  logic                      req_voxel_value,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [COORD_W-1:0]        csr_data,
   input  logic                      rsp_valid,
   input  logic [1:0]                rsp_face_axis,
   input  logic                      rsp_normal_negative,
   input  logic signed [COORD_W-1:0] rsp_base_x,
   input  logic signed [COORD_W-1:0] rsp_base_y,
   input  logic [COORD_W-1:0]        rsp_base_z,
   input  logic [1:0]                rsp_occlusion_a,
   input  logic [1:0]                rsp_occlusion_b,
   input  logic [1:0]                rsp_occlusion_c,
   input  logic [1:0]                rsp_occlusion_d,
   input  logic                      rsp_last_face,
   output int                        fail_count,
   output int                        pending,
   output int                        faces_checked
);

   typedef struct packed {
      axis_type           axis;
      logic               neg;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
      logic [COORD_W-1:0] bz;
      logic [1:0]         oa;
      logic [1:0]         ob;
      logic [1:0]         oc;
      logic [1:0]         od;
      logic               last;
   } face_type;

   bit                 voxel_bits [MEM_DEPTH];
   logic [COORD_W-1:0] width_reg  = GRID_RESET;
   logic [COORD_W-1:0] height_reg = GRID_RESET;
   logic [COORD_W-1:0] depth_reg  = GRID_RESET;
   face_type           faces_due [$];
   int                 mismatches = 0;
   int                 faces_seen = 0;

   // sizes above the grid limit behave as the limit
   function automatic int span(logic [COORD_W-1:0] r, int limit);
      return (int'(r) > limit) ? limit : int'(r);
   endfunction

   // below the floor is air, any other cell off the grid is rock
   function automatic bit solid_at(int x, int y, int z);
      if (z < 0)
         return 1'b0;
      if (x < 0 || y < 0 || x >= span(width_reg, MAX_WIDTH) ||
          y >= span(height_reg, MAX_HEIGHT) || z >= span(depth_reg, MAX_DEPTH))
         return 1'b1;
      return voxel_bits[(z * MAX_HEIGHT + y) * MAX_WIDTH + x];
   endfunction

   function automatic logic [1:0] shade(bit side0, bit side1, bit corner);
      if (side0 && side1)
         return 2'd3;
      return 2'(int'(side0) + int'(side1) + int'(corner));
   endfunction

   function automatic logic [COORD_W-1:0] screen_base(int c, logic [COORD_W-1:0] r);
      int v;
      v = (2 * c - int'(r)) / 2;
      return v[COORD_W-1:0];
   endfunction

   task automatic predict_faces(int x, int y, int z);
      face_type found [$];
      face_type f;
      bit    mid, top, left, bottom, right, tl, tr, bl, br;
      int    nx, ny, nz, ux, uy, uz, vx, vy, vz, cx, cy, cz;
      mid = solid_at(x, y, z);
      for (int a = 0; a < 3; a++) begin
         // normal, then the two in-plane directions of this axis
         nx = (a == 0);  ny = (a == 1);  nz = (a == 2);
         ux = (a == 2);  uy = (a == 0);  uz = (a == 1);
         vx = (a == 1);  vy = (a == 2);  vz = (a == 0);
         if (solid_at(x - nx, y - ny, z - nz) == mid)
            continue;
         // drop +z faces; solid cells hand the face to the neighbor below
         if (!mid && a == 2)
            continue;
         cx = mid ? x - nx : x;
         cy = mid ? y - ny : y;
         cz = mid ? z - nz : z;
         top    = solid_at(cx - vx, cy - vy, cz - vz);
         left   = solid_at(cx - ux, cy - uy, cz - uz);
         bottom = solid_at(cx + vx, cy + vy, cz + vz);
         right  = solid_at(cx + ux, cy + uy, cz + uz);
         tl     = solid_at(cx - ux - vx, cy - uy - vy, cz - uz - vz);
         tr     = solid_at(cx + ux - vx, cy + uy - vy, cz + uz - vz);
         bl     = solid_at(cx - ux + vx, cy - uy + vy, cz - uz + vz);
         br     = solid_at(cx + ux + vx, cy + uy + vy, cz + uz + vz);
         f.axis = axis_type'(a);
         f.neg  = mid;
         f.bx   = screen_base(x, width_reg);
         f.by   = screen_base(y, height_reg);
         f.bz   = COORD_W'(z);
         f.oa   = shade(top, left, tl);
         f.ob   = shade(top, right, tr);
         f.oc   = shade(bottom, left, bl);
         f.od   = shade(bottom, right, br);
         f.last = 1'b0;
         found.push_back(f);
      end
      if (found.size() > 0)
         found[found.size() - 1].last = 1'b1;
      foreach (found[i])
         faces_due.push_back(found[i]);
   endtask

   always @(posedge clock) begin
      face_type got;
      face_type want;
      if (reset) begin
         width_reg  = GRID_RESET;
         height_reg = GRID_RESET;
         depth_reg  = GRID_RESET;
         faces_due.delete();
      end else begin
         if (rsp_valid) begin
            got.axis = axis_type'(rsp_face_axis);
            got.neg  = rsp_normal_negative;
            got.bx   = rsp_base_x;
            got.by   = rsp_base_y;
            got.bz   = rsp_base_z;
            got.oa   = rsp_occlusion_a;
            got.ob   = rsp_occlusion_b;
            got.oc   = rsp_occlusion_c;
            got.od   = rsp_occlusion_d;
            got.last = rsp_last_face;
            faces_seen++;
            if (faces_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: face with no scan waiting: axis=%0d neg=%0b last=%0b",
                           $realtime, got.axis, got.neg, got.last);
            end else begin
               want = faces_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: face mismatch", $realtime);
                     $display("  expected axis=%0d neg=%0b base=(%0d,%0d,%0d) ao=%0d/%0d/%0d/%0d last=%0b",
                              want.axis, want.neg, $signed(want.bx), $signed(want.by),
                              want.bz, want.oa, want.ob, want.oc, want.od, want.last);
                     $display("  actual   axis=%0d neg=%0b base=(%0d,%0d,%0d) ao=%0d/%0d/%0d/%0d last=%0b",
                              got.axis, got.neg, $signed(got.bx), $signed(got.by),
                              got.bz, got.oa, got.ob, got.oc, got.od, got.last);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  width_reg  = csr_data;
               CSR_HEIGHT: height_reg = csr_data;
               CSR_DEPTH:  depth_reg  = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_opcode == OP_WRITE) begin
               // drop writes outside the grid in use
               if (int'(req_cell_x) < span(width_reg, MAX_WIDTH) &&
                   int'(req_cell_y) < span(height_reg, MAX_HEIGHT) &&
                   int'(req_cell_z) < span(depth_reg, MAX_DEPTH))
                  voxel_bits[(int'(req_cell_z) * MAX_HEIGHT + int'(req_cell_y)) * MAX_WIDTH
                             + int'(req_cell_x)] = req_voxel_value;
            end else begin
               predict_faces(req_cell_x, req_cell_y, req_cell_z);
            end
         end
      end
      fail_count    <= mismatches;
      pending       <= faces_due.size();
      faces_checked <= faces_seen;
   end

endmodule

// File: sim/voxel_face_ao_extractor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_ao_extractor_test
// Drives voxel writes and cell scans into the extractor over a series of
// grid sizes, small ones mostly, plus the full grid, a zero size and an
// oversize register. Every cell a scan can read is written first. The
// checker beside the block predicts and compares each face.
// ----------------------------------------------------------------------------
module voxel_face_ao_extractor_test;
   import vfae_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int GRID_PHASES   = 9;
   localparam int PHASE_ITEMS   = 32;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      start           = 1'b0;
   logic                      busy;
   logic                      req_opcode      = 1'b0;
   logic [COORD_W-1:0]        req_cell_x      = '0;
   logic [COORD_W-1:0]        req_cell_y      = '0;
   logic [COORD_W-1:0]        req_cell_z      = '0;
   logic                      req_voxel_value = 1'b0;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_index       = '0;
   logic [COORD_W-1:0]        csr_data        = '0;
   logic                      rsp_valid;
   logic [1:0]                rsp_face_axis;
   logic                      rsp_normal_negative;
   logic signed [COORD_W-1:0] rsp_base_x;
   logic signed [COORD_W-1:0] rsp_base_y;
   logic [COORD_W-1:0]        rsp_base_z;
   logic [1:0]                rsp_occlusion_a;
   logic [1:0]                rsp_occlusion_b;
   logic [1:0]                rsp_occlusion_c;
   logic [1:0]                rsp_occlusion_d;
   logic                      rsp_last_face;

   int fail_count;
   int pending;
   int faces_checked;

   bit voxel_known [MEM_DEPTH];
   int grid_reg [3] = '{32, 32, 32};
   int idle_pct     = 16;
   int items_sent   = 0;
   int scans_sent   = 0;
   int writes_sent  = 0;
   int cycle_count  = 0;

   voxel_face_ao_extractor dut (.*);

   voxel_face_checker face_check (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("voxel_face_ao_extractor_test NOT OK");
         $finish;
      end
   end

   function automatic int in_use(int r, int limit);
      return (r > limit) ? limit : r;
   endfunction

   function automatic bit holds(int x, int y, int z);
      return x >= 0 && y >= 0 && z >= 0 &&
             x < in_use(grid_reg[CSR_WIDTH], MAX_WIDTH) &&
             y < in_use(grid_reg[CSR_HEIGHT], MAX_HEIGHT) &&
             z < in_use(grid_reg[CSR_DEPTH], MAX_DEPTH);
   endfunction

   // stay near the corners of big grids so few cells need priming
   function automatic int pick_coord(int r, int limit);
      int e;
      e = in_use(r, limit);
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, limit);
      if (e <= 6)
         return $urandom_range(0, e);
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, 2);
      return $urandom_range(e - 2, e);
   endfunction

   // leaves start high; the caller either issues again in this step or rests
   task automatic issue(opcode_type op, int x, int y, int z, bit v);
      req_opcode      <= op;
      req_cell_x      <= COORD_W'(x);
      req_cell_y      <= COORD_W'(y);
      req_cell_z      <= COORD_W'(z);
      req_voxel_value <= v;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic rest(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_voxel(int x, int y, int z, bit v);
      issue(OP_WRITE, x, y, z, v);
      writes_sent++;
      if (holds(x, y, z))
         voxel_known[(z * MAX_HEIGHT + y) * MAX_WIDTH + x] = 1'b1;
   endtask

   // prime every cell of the 3x3x3 block the scan may read
   task automatic scan_cell(int x, int y, int z);
      for (int dz = -1; dz <= 1; dz++)
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
               if (holds(x + dx, y + dy, z + dz) &&
                   !voxel_known[((z + dz) * MAX_HEIGHT + y + dy) * MAX_WIDTH + x + dx])
                  write_voxel(x + dx, y + dy, z + dz, $urandom_range(0, 1));
      issue(OP_SCAN, x, y, z, $urandom_range(0, 1));
      scans_sent++;
   endtask

   task automatic csr_write(csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= COORD_W'(value);
      do @(posedge clock); while (!csr_ready);
      grid_reg[idx] = value;
   endtask

   // change sizes only once the block has gone quiet
   task automatic set_grid(int w, int h, int d);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_WIDTH, w);
      csr_write(CSR_HEIGHT, h);
      csr_write(CSR_DEPTH, d);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: tiny grid, empty cells, a solid cell with all three faces,
      // cells off the grid, writes off the grid
      set_grid(2, 2, 2);
      for (int z = 0; z < 2; z++)
         for (int y = 0; y < 2; y++)
            for (int x = 0; x < 2; x++)
               write_voxel(x, y, z, 1'b0);
      scan_cell(0, 0, 0);
      scan_cell(1, 1, 1);
      write_voxel(1, 1, 1, 1'b1);
      scan_cell(1, 1, 1);
      scan_cell(1, 0, 0);
      scan_cell(0, 1, 1);
      scan_cell(2, 2, 2);
      write_voxel(2, 0, 0, 1'b1);
      write_voxel(0, 0, 2, 1'b1);
      write_voxel(32, 32, 32, 1'b1);
      scan_cell(32, 32, 32);
      scan_cell(0, 1, 0);

      for (int p = 0; p < GRID_PHASES; p++) begin
         int ex, ey, ez, x, y, z, pick, phase_start;
         idle_pct = (p < 3) ? 16 : (p < 6) ? 45 : 0;
         case (p)
            0: set_grid(4, 4, 4);
            1: set_grid(1, 1, 1);
            2: set_grid(32, 32, 32);
            3: set_grid(5, 3, 6);
            4: set_grid(0, 3, 3);
            5: set_grid(63, 4, 2);
            6: set_grid(2, 32, 3);
            7: set_grid(6, 6, 6);
            default: set_grid(3, 5, 32);
         endcase
         ex = in_use(grid_reg[CSR_WIDTH], MAX_WIDTH);
         ey = in_use(grid_reg[CSR_HEIGHT], MAX_HEIGHT);
         ez = in_use(grid_reg[CSR_DEPTH], MAX_DEPTH);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            x = pick_coord(grid_reg[CSR_WIDTH], MAX_WIDTH);
            y = pick_coord(grid_reg[CSR_HEIGHT], MAX_HEIGHT);
            z = pick_coord(grid_reg[CSR_DEPTH], MAX_DEPTH);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               scan_cell(x, y, z);
            end else if (pick < 90 && ex > 0 && ey > 0 && ez > 0) begin
               write_voxel((x < ex) ? x : ex - 1, (y < ey) ? y : ey - 1,
                           (z < ez) ? z : ez - 1, $urandom_range(0, 1));
            end else begin
               // push one coordinate past the grid so the write is dropped
               case ($urandom_range(0, 2))
                  0: x = $urandom_range(ex, MAX_WIDTH);
                  1: y = $urandom_range(ey, MAX_HEIGHT);
                  default: z = $urandom_range(ez, MAX_DEPTH);
               endcase
               write_voxel(x, y, z, $urandom_range(0, 1));
            end
            if ($urandom_range(0, 99) < 2)
               drain();
            else if ($urandom_range(0, 99) < idle_pct)
               rest($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 3));
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d requests: %0d scans, %0d voxel writes, over %0d grid sizes",
               items_sent, scans_sent, writes_sent, GRID_PHASES + 1);
      $display("checked %0d faces, %0d mismatches", faces_checked, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("voxel_face_ao_extractor_test OK");
      else
         $display("voxel_face_ao_extractor_test NOT OK");
      $finish;
   end

endmodule
